// ----- src/fxalu_pkg.sv -----
// Package with widths, action codes and status codes of the Q24.8 ALU.
package fxalu_pkg;

  localparam int FracBits = 8;
  localparam int WordBits = 32;
  localparam int QuotBits = WordBits + FracBits + 1;
  localparam int DivStages = 7;
  localparam int BitsPerStage = (QuotBits + DivStages - 1) / DivStages;
  localparam int QuotPad = BitsPerStage * DivStages;
  localparam int NumBits = QuotPad;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [WordBits:0] mag_t;

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
    ACT_MIN = 4'd4, ACT_MAX = 4'd5, ACT_GT = 4'd6, ACT_LT = 4'd7,
    ACT_GE = 4'd8, ACT_LE = 4'd9, ACT_EQ = 4'd10, ACT_NE = 4'd11,
    ACT_INC = 4'd12, ACT_DEC = 4'd13
  } action_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_SAT = 2'd1, ST_DIV0 = 2'd2
  } status_t;

  // Operation state travelling along the divider stages.
  typedef struct packed {
    logic [NumBits-1:0] num;
    mag_t den;
    mag_t rem;
    logic [QuotPad-1:0] quot;
  } div_state_t;

endpackage

// ----- src/fxalu_div_stage.sv -----
// One combinational slice of restoring long division, several quotient bits.
module fxalu_div_stage (
  input  fxalu_pkg::div_state_t din,
  output fxalu_pkg::div_state_t dout
);

  localparam int Nb = fxalu_pkg::NumBits;
  localparam int Bs = fxalu_pkg::BitsPerStage;
  localparam int Wb = fxalu_pkg::WordBits;

  // Shift in one numerator bit a step and subtract where it fits.
  always_comb begin
    logic [Wb+1:0] r;
    fxalu_pkg::div_state_t s;
    s = din;
    for (int i = 0; i < Bs; i++) begin
      r = {s.rem, s.num[Nb-1]};
      s.num = {s.num[Nb-2:0], 1'b0};
      s.quot = {s.quot[fxalu_pkg::QuotPad-2:0], 1'b0};
      if (r >= {1'b0, s.den}) begin
        r = r - {1'b0, s.den};
        s.quot[0] = 1'b1;
      end
      s.rem = r[Wb:0];
    end
    dout = s;
  end

endmodule

// ----- src/fixed_point_q24_8_alu.sv -----
// Top level of the pipelined Q24.8 fixed-point ALU.
// Channel | Direction | tdata fields (low bit up)
// s_axis  | in        | action[3:0], operand_a[35:4], operand_b[67:36], pad to 72
// m_axis  | out       | result_value[31:0], compare_true[32], status[34:33], pad to 40
// Ten register stages; an item passes through all of them to reach m_axis, and
// one item can enter every cycle while m_axis does not stall.
// Stage 1 forms magnitudes, stages 2 to 8 run the divider slices while the
// product rides along, stage 9 rounds and saturates, stage 10 is the output register.
// A stall at m_axis freezes the whole pipeline; nothing is lost or repeated.
// Reset clears only the valid bits.
module fixed_point_q24_8_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // action, operand_a, operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // result_value, compare_true, status
);

  localparam int Wb = fxalu_pkg::WordBits;
  localparam int Fb = fxalu_pkg::FracBits;
  localparam int Ds = fxalu_pkg::DivStages;
  localparam int Last = Ds + 1;
  localparam int Mw = 2 * Wb + 2;

  typedef struct packed {
    logic [3:0] act;
    logic neg;
    logic [Wb-1:0] fast;
    logic cmp;
    logic [1:0] st;
  } ctl_t;

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic [3:0] in_act;
  logic signed [Wb-1:0] in_a, in_b;
  assign in_act = s_axis_tdata[3:0];
  assign in_a = s_axis_tdata[35:4];
  assign in_b = s_axis_tdata[67:36];

  // Add, sub, inc, dec, min, max and comparisons finish at once.
  ctl_t c0;
  always_comb begin
    logic signed [Wb:0] sum;
    logic signed [Wb-1:0] opb;
    logic sub;
    c0 = '0;
    c0.act = in_act;
    c0.neg = in_a[Wb-1] ^ in_b[Wb-1];
    sub = (in_act == fxalu_pkg::ACT_SUB) || (in_act == fxalu_pkg::ACT_DEC);
    opb = ((in_act == fxalu_pkg::ACT_INC) || (in_act == fxalu_pkg::ACT_DEC))
          ? Wb'(signed'(1)) : in_b;
    sum = sub ? ({in_a[Wb-1], in_a} - {opb[Wb-1], opb})
              : ({in_a[Wb-1], in_a} + {opb[Wb-1], opb});
    case (in_act)
      fxalu_pkg::ACT_ADD, fxalu_pkg::ACT_SUB, fxalu_pkg::ACT_INC,
      fxalu_pkg::ACT_DEC: begin
        if (sum[Wb] != sum[Wb-1]) begin
          c0.st = fxalu_pkg::ST_SAT;
          c0.fast = sum[Wb] ? {1'b1, {(Wb-1){1'b0}}} : {1'b0, {(Wb-1){1'b1}}};
        end else begin
          c0.fast = sum[Wb-1:0];
        end
      end
      fxalu_pkg::ACT_DIV: if (in_b == '0) c0.st = fxalu_pkg::ST_DIV0;
      fxalu_pkg::ACT_MIN: c0.fast = (in_a > in_b) ? in_b : in_a;
      fxalu_pkg::ACT_MAX: c0.fast = (in_a > in_b) ? in_a : in_b;
      fxalu_pkg::ACT_GT: c0.cmp = in_a > in_b;
      fxalu_pkg::ACT_LT: c0.cmp = in_a < in_b;
      fxalu_pkg::ACT_GE: c0.cmp = in_a >= in_b;
      fxalu_pkg::ACT_LE: c0.cmp = in_a <= in_b;
      fxalu_pkg::ACT_EQ: c0.cmp = in_a == in_b;
      fxalu_pkg::ACT_NE: c0.cmp = in_a != in_b;
      default: ;
    endcase
  end

  // Stage 1: magnitudes and the initial divider state.
  logic v1;
  ctl_t c1;
  fxalu_pkg::mag_t ma1, mb1;
  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= c0;
      ma1 <= in_a[Wb-1] ? (Wb+1)'(-{in_a[Wb-1], in_a}) : {1'b0, in_a};
      mb1 <= in_b[Wb-1] ? (Wb+1)'(-{in_b[Wb-1], in_b}) : {1'b0, in_b};
    end
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_axis_tvalid;
  end

  fxalu_pkg::div_state_t dinit;
  always_comb begin
    dinit = '0;
    dinit.num = fxalu_pkg::NumBits'({ma1, {Fb{1'b0}}});
    dinit.den = (mb1 == '0) ? (Wb+1)'(1) : mb1;
  end

  // Stages 2 to 8: divider slices; the product rides along.
  logic v [2:Last];
  ctl_t c [2:Last];
  fxalu_pkg::div_state_t dreg [1:Ds];
  logic [Mw-1:0] prod [2:Last];
  fxalu_pkg::div_state_t dnx [1:Ds];

  for (genvar g = 1; g <= Ds; g++) begin : g_div
    if (g == 1) begin : g_first
      fxalu_div_stage u_stage (.din(dinit), .dout(dnx[g]));
    end else begin : g_rest
      fxalu_div_stage u_stage (.din(dreg[g-1]), .dout(dnx[g]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c[2] <= c1;
      prod[2] <= ma1 * mb1;
      for (int k = 1; k <= Ds; k++) dreg[k] <= dnx[k];
      for (int k = 3; k <= Last; k++) begin
        c[k] <= c[k-1];
        prod[k] <= prod[k-1];
      end
    end
    if (rst) begin
      for (int k = 2; k <= Last; k++) v[k] <= 1'b0;
    end else if (adv) begin
      v[2] <= v1;
      for (int k = 3; k <= Last; k++) v[k] <= v[k-1];
    end
  end

  // Stage 9: rounding and saturation of product and quotient.
  logic v5;
  ctl_t c5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v[Last];
  end

  always_ff @(posedge clk) begin
    logic [Mw-1:0] rp;
    logic [fxalu_pkg::QuotPad:0] rq;
    logic [Mw-1:0] mg;
    logic [Mw-1:0] lim;
    ctl_t t;
    if (adv) begin
      t = c[Last];
      rp = (prod[Last] + Mw'(1 << (Fb - 1))) >> Fb;
      rq = {1'b0, dreg[Ds].quot} +
           ((({1'b0, dreg[Ds].rem} << 1) >= {1'b0, dreg[Ds].den}) ? 1 : 0);
      mg = (t.act == fxalu_pkg::ACT_MUL) ? rp : Mw'(rq);
      lim = t.neg ? Mw'({1'b1, {(Wb-1){1'b0}}}) : Mw'({1'b0, {(Wb-1){1'b1}}});
      if ((t.act == fxalu_pkg::ACT_MUL) ||
          ((t.act == fxalu_pkg::ACT_DIV) && (t.st != fxalu_pkg::ST_DIV0))) begin
        if (mg > lim) begin
          t.st = fxalu_pkg::ST_SAT;
          t.fast = t.neg ? {1'b1, {(Wb-1){1'b0}}} : {1'b0, {(Wb-1){1'b1}}};
        end else begin
          t.fast = t.neg ? Wb'(-mg) : mg[Wb-1:0];
        end
      end
      c5 <= t;
    end
  end

  // Stage 10: output register.
  always_ff @(posedge clk) begin
    if (adv) m_axis_tdata <= {5'd0, c5.st, c5.cmp, c5.fast};
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= v5;
  end

endmodule
